### sv/csvfs_pkg.sv
// ----------------------------------------------------------------------------
// CSV field splitter package
// Shared result codes, parse modes, result types and the result-list helper.
// ----------------------------------------------------------------------------
package csvfs_pkg;

  localparam int MaxResults = 3;

  // Result kinds
  localparam logic [1:0] KIND_CONTENT    = 2'd0;
  localparam logic [1:0] KIND_FIELD_END  = 2'd1;
  localparam logic [1:0] KIND_ERROR      = 2'd2;
  localparam logic [1:0] KIND_RECORD_END = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNQUOTED   = 2'd1;
  localparam logic [1:0] ERR_LONE_QUOTE = 2'd2;
  localparam logic [1:0] ERR_QUOTED_END = 2'd3;

  // Parse modes
  localparam logic [2:0] MODE_START  = 3'd0;
  localparam logic [2:0] MODE_UNQ    = 3'd1;
  localparam logic [2:0] MODE_QUOTED = 3'd2;
  localparam logic [2:0] MODE_QSEEN  = 3'd3;
  localparam logic [2:0] MODE_ERROR  = 3'd4;

  // Special bytes
  localparam logic [7:0] BYTE_QUOTE = 8'h22;
  localparam logic [7:0] BYTE_LF    = 8'h0A;
  localparam logic [7:0] BYTE_CR    = 8'h0D;

  localparam logic [7:0] DELIM_RESET = 8'd44;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] code;
  } result_t;

  // Up to three results caused by one item, in order from index 0
  typedef struct packed {
    result_t [MaxResults-1:0] res;
    logic [1:0]               count;
  } bundle_t;

  function automatic bundle_t push_result(bundle_t b, logic [1:0] kind,
                                          logic [7:0] data, logic [1:0] code);
    bundle_t nb;
    nb = b;
    nb.res[nb.count].kind = kind;
    nb.res[nb.count].data = data;
    nb.res[nb.count].code = code;
    nb.count = nb.count + 2'd1;
    return nb;
  endfunction

endpackage

### sv/csvfs_decode.sv
// ----------------------------------------------------------------------------
// CSV field splitter decoder
// Works out the result list and the next parse mode for one record byte.
// ----------------------------------------------------------------------------
module csvfs_decode (
  input  logic [2:0]       mode,
  input  logic [7:0]       data_byte,
  input  logic             record_end,
  input  logic [7:0]       delimiter,
  output csvfs_pkg::bundle_t bundle,
  output logic [2:0]       mode_next
);
  import csvfs_pkg::*;

  logic    [2:0] m;
  logic    [2:0] mn;
  bundle_t       b;
  logic          is_delim;
  logic          is_quote;
  logic          is_brk;

  assign is_delim = (data_byte == delimiter);
  assign is_quote = (data_byte == BYTE_QUOTE);
  assign is_brk   = (data_byte == BYTE_CR) || (data_byte == BYTE_LF);

  always_comb begin
    b  = '0;
    m  = (mode > MODE_ERROR) ? MODE_START : mode;
    mn = m;
    case (m)
      MODE_START: begin
        if (is_brk) begin
          mn = m;
        end else if (is_quote) begin
          if (record_end) begin
            b  = push_result(b, KIND_ERROR, 8'd0, ERR_QUOTED_END);
            mn = MODE_ERROR;
          end else begin
            mn = MODE_QUOTED;
          end
        end else if (is_delim) begin
          b = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
        end else begin
          b = push_result(b, KIND_CONTENT, data_byte, ERR_NONE);
          if (record_end) b = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
          else            mn = MODE_UNQ;
        end
      end
      MODE_UNQ: begin
        if (is_delim) begin
          b  = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
          mn = MODE_START;
        end else if (is_quote || is_brk) begin
          b  = push_result(b, KIND_ERROR, 8'd0, ERR_UNQUOTED);
          mn = MODE_ERROR;
        end else begin
          b = push_result(b, KIND_CONTENT, data_byte, ERR_NONE);
          if (record_end) b = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
        end
      end
      MODE_QUOTED: begin
        if (is_quote) begin
          if (record_end) b = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
          else            mn = MODE_QSEEN;
        end else if (record_end) begin
          b  = push_result(b, KIND_ERROR, 8'd0, ERR_QUOTED_END);
          mn = MODE_ERROR;
        end else begin
          b = push_result(b, KIND_CONTENT, data_byte, ERR_NONE);
        end
      end
      MODE_QSEEN: begin
        if (is_delim) begin
          b  = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
          mn = MODE_START;
        end else if (is_quote) begin
          b = push_result(b, KIND_CONTENT, BYTE_QUOTE, ERR_NONE);
          if (record_end) begin
            b  = push_result(b, KIND_ERROR, 8'd0, ERR_QUOTED_END);
            mn = MODE_ERROR;
          end else begin
            mn = MODE_QUOTED;
          end
        end else begin
          b  = push_result(b, KIND_ERROR, 8'd0, ERR_LONE_QUOTE);
          mn = MODE_ERROR;
        end
      end
      default: begin
        mn = m; // drop bytes until the record ends
      end
    endcase

    // Record close: trailing delimiter adds an empty field, then the end mark
    if (record_end) begin
      if ((mn != MODE_ERROR) && is_delim)
        b = push_result(b, KIND_FIELD_END, 8'd0, ERR_NONE);
      b  = push_result(b, KIND_RECORD_END, 8'd0, ERR_NONE);
      mn = MODE_START;
    end
  end

  assign bundle    = b;
  assign mode_next = mn;

endmodule

### sv/csvfs_out_stage.sv
// ----------------------------------------------------------------------------
// CSV field splitter output stage
// Holds one item's results, handing out one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module csvfs_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  csvfs_pkg::bundle_t bundle_in,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic [7:0]         out_byte,
  output logic [1:0]         error_code,
  output logic               last_of_item
);
  import csvfs_pkg::*;

  bundle_t    bundle;
  logic       valid;
  logic [1:0] idx;
  logic       last;
  result_t    cur;

  assign cur  = bundle.res[idx];
  assign last = (idx == (bundle.count - 2'd1));
  assign free = !valid || (out_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= 2'd0;
    end else if (load) begin
      valid <= 1'b1;
      idx   <= 2'd0;
    end else if (valid && out_ready) begin
      if (last) valid <= 1'b0;
      else      idx   <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bundle <= bundle_in;
  end

  assign out_valid    = valid;
  assign kind         = cur.kind;
  assign out_byte     = cur.data;
  assign error_code   = cur.code;
  assign last_of_item = last;

endmodule

### sv/csv_field_splitter.sv
// ----------------------------------------------------------------------------
// CSV field splitter
// Splits delimited text records, one byte per item, into field results.
// ----------------------------------------------------------------------------
// Feed one record byte per item with record_end set on the last byte. Each
// item gives zero to three results (content byte, field end, error, record
// end), delivered one per cycle while out_ready is high, with last_of_item
// marking the final result of the item. An item is decoded against the
// parse mode in the input register, and its results move into the output
// stage register once that stage is free. The input side takes one item
// per cycle while each item gives at most one result and out_ready stays
// high; an item that gives several results holds the single output port
// until its last result is taken, and the input stalls behind it. The
// delimiter must be written through the cfg port only while the block is
// idle; the block does not enforce this. It resets to a comma.
// ----------------------------------------------------------------------------
module csv_field_splitter (
  input  logic       clk,
  input  logic       rst,
  // configuration write
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] field_delimiter,
  // record bytes in
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       record_end,
  // results out
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic [7:0] out_byte,
  output logic [1:0] error_code,
  output logic       last_of_item
);
  import csvfs_pkg::*;

  // Delimiter register
  logic [7:0] delimiter;

  // Input register
  logic       in_full;
  logic [7:0] byte_q;
  logic       end_q;

  // Parse mode
  logic [2:0] mode;
  logic [2:0] mode_next;

  bundle_t    bundle;
  logic       free;
  logic       advance;
  logic       load;

  // Always able to take a delimiter write
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delimiter <= DELIM_RESET;
    end else if (cfg_valid) begin
      delimiter <= field_delimiter;
    end
  end

  csvfs_decode u_decode (
    .mode       (mode),
    .data_byte  (byte_q),
    .record_end (end_q),
    .delimiter  (delimiter),
    .bundle     (bundle),
    .mode_next  (mode_next)
  );

  // Advance the held item when its results fit: none at all, or the output
  // stage is empty or hands out its final result this cycle.
  assign advance  = in_full && ((bundle.count == 2'd0) || free);
  assign load     = advance && (bundle.count != 2'd0);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      mode    <= MODE_START;
    end else begin
      if (in_valid && in_ready) in_full <= 1'b1;
      else if (advance)         in_full <= 1'b0;
      if (advance) mode <= mode_next;
    end
  end

  // Hold the payload of the item under decode
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= data_byte;
      end_q  <= record_end;
    end
  end

  csvfs_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .bundle_in    (bundle),
    .free         (free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .out_byte     (out_byte),
    .error_code   (error_code),
    .last_of_item (last_of_item)
  );

endmodule

### sv/csvfs_checker.sv
// ----------------------------------------------------------------------------
// CSV field splitter checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module csvfs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic [7:0] out_byte,
  input logic [1:0] error_code,
  input logic       last_of_item
);
  import csvfs_pkg::*;

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(error_code) && $stable(last_of_item))
    else $error("result changed while stalled");

  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_CONTENT) |-> (out_byte == 8'd0))
    else $error("non-content result carries a byte");

  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == KIND_ERROR) == (error_code != ERR_NONE)))
    else $error("error code does not match kind");

  a_rec_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_RECORD_END) |-> last_of_item)
    else $error("record end is not the last result of its item");

endmodule

bind csv_field_splitter csvfs_checker u_csvfs_checker (.*);

### sim/csv_field_splitter_checker.sv
// ----------------------------------------------------------------------------
// CSV field splitter checker
// Watches the cfg, byte and result channels. Tracks the parse mode and the
// delimiter, and works out the tokens that each accepted byte must give.
// Compares every accepted result, in order, against the oldest token due.
// ----------------------------------------------------------------------------
module csv_field_splitter_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] field_delimiter,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       record_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [1:0] kind,
  input  logic [7:0] out_byte,
  input  logic [1:0] error_code,
  input  logic       last_of_item,
  output int         token_faults,
  output int         tokens_owed
);
  import csvfs_pkg::*;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] content;
    logic [1:0] code;
    logic       last;
  } csv_token_t;

  csv_token_t tokens_due[$];
  csv_token_t byte_tokens[MaxResults];
  int         byte_token_count;
  logic [7:0] delim;
  logic [2:0] mode;

  function automatic void add_token(logic [1:0] k, logic [7:0] c, logic [1:0] e);
    byte_tokens[byte_token_count].kind    = k;
    byte_tokens[byte_token_count].content = c;
    byte_tokens[byte_token_count].code    = e;
    byte_tokens[byte_token_count].last    = 1'b0;
    byte_token_count++;
  endfunction

  function automatic void add_error(logic [1:0] e);
    add_token(KIND_ERROR, 8'h00, e);
    mode = MODE_ERROR;
  endfunction

  // Advance the parse mode by one byte and queue the tokens it gives
  function automatic void split_byte(logic [7:0] d, logic last_byte);
    csv_token_t tok;
    byte_token_count = 0;
    if (mode > MODE_ERROR) mode = MODE_START;
    case (mode)
      MODE_START: begin
        if (d == BYTE_CR || d == BYTE_LF) begin
          // line breaks between fields give nothing
        end else if (d == BYTE_QUOTE) begin
          if (last_byte) add_error(ERR_QUOTED_END);
          else mode = MODE_QUOTED;
        end else if (d == delim) begin
          add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
        end else begin
          add_token(KIND_CONTENT, d, ERR_NONE);
          if (last_byte) add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
          else mode = MODE_UNQ;
        end
      end
      MODE_UNQ: begin
        if (d == delim) begin
          add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
          mode = MODE_START;
        end else if (d == BYTE_QUOTE || d == BYTE_CR || d == BYTE_LF) begin
          add_error(ERR_UNQUOTED);
        end else begin
          add_token(KIND_CONTENT, d, ERR_NONE);
          if (last_byte) add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
        end
      end
      MODE_QUOTED: begin
        if (d == BYTE_QUOTE) begin
          if (last_byte) add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
          else mode = MODE_QSEEN;
        end else if (last_byte) begin
          add_error(ERR_QUOTED_END);
        end else begin
          add_token(KIND_CONTENT, d, ERR_NONE);
        end
      end
      MODE_QSEEN: begin
        if (d == delim) begin
          add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
          mode = MODE_START;
        end else if (d == BYTE_QUOTE) begin
          add_token(KIND_CONTENT, BYTE_QUOTE, ERR_NONE);
          if (last_byte) add_error(ERR_QUOTED_END);
          else mode = MODE_QUOTED;
        end else begin
          add_error(ERR_LONE_QUOTE);
        end
      end
      default: begin
        // drop bytes until the record ends
      end
    endcase
    if (last_byte) begin
      if (mode != MODE_ERROR && d == delim) add_token(KIND_FIELD_END, 8'h00, ERR_NONE);
      add_token(KIND_RECORD_END, 8'h00, ERR_NONE);
      mode = MODE_START;
    end
    for (int i = 0; i < byte_token_count; i++) begin
      tok = byte_tokens[i];
      tok.last = (i == byte_token_count - 1);
      tokens_due = {tokens_due, tok};
    end
  endfunction

  always @(posedge clk) begin
    csv_token_t want;
    if (rst) begin
      delim = DELIM_RESET;
      mode  = MODE_START;
      tokens_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          token_faults++;
          $display("%0t: result with none due: got kind=%0d byte=%02h code=%0d last=%0b",
                   $time, kind, out_byte, error_code, last_of_item);
        end else begin
          want = tokens_due.pop_front();
          if (kind !== want.kind || out_byte !== want.content ||
              error_code !== want.code || last_of_item !== want.last) begin
            token_faults++;
            $display("%0t: mismatch: expected kind=%0d byte=%02h code=%0d last=%0b",
                     $time, want.kind, want.content, want.code, want.last);
            $display("%0t:           actual kind=%0d byte=%02h code=%0d last=%0b",
                     $time, kind, out_byte, error_code, last_of_item);
          end
        end
      end
      if (cfg_valid && cfg_ready) delim = field_delimiter;
      if (in_valid && in_ready) split_byte(data_byte, record_end);
    end
    tokens_owed <= tokens_due.size();
  end

endmodule

### sim/csv_field_splitter_test.sv
// ----------------------------------------------------------------------------
// CSV field splitter regression
// Drives records byte by byte under several delimiters and idling patterns;
// a checker beside the block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module csv_field_splitter_test;
  import csvfs_pkg::*;

  localparam int StallLimit   = 2000; // cycles with no handshake before giving up
  localparam int LongHold     = 60;   // receiver hold-off used to back the block up
  localparam int SettleCycles = 8;    // settling time in drain, for a byte that gives no result

  logic       clk             = 1'b0;
  logic       rst             = 1'b1;
  logic       cfg_valid       = 1'b0;
  logic       cfg_ready;
  logic [7:0] field_delimiter = DELIM_RESET;
  logic       in_valid        = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte       = 8'h00;
  logic       record_end      = 1'b0;
  logic       out_valid;
  logic       out_ready       = 1'b0;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [1:0] error_code;
  logic       last_of_item;

  int token_faults;
  int tokens_owed;

  // Idling odds, in percent per cycle
  int send_gap_pct = 0;
  int recv_gap_pct = 0;

  // Long receiver hold-off: the stimulus flips hold_toggle, the receiver
  // notices the change and counts the hold down itself
  logic hold_toggle = 1'b0;
  logic hold_seen   = 1'b0;
  int   hold_left   = 0;

  int         quiet_cycles = 0;
  logic [7:0] delim_now;
  logic [7:0] record_bytes[$];

  always #5 clk = ~clk;

  csv_field_splitter i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .field_delimiter (field_delimiter),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .record_end      (record_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_byte        (out_byte),
    .error_code      (error_code),
    .last_of_item    (last_of_item)
  );

  csv_field_splitter_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .field_delimiter (field_delimiter),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .record_end      (record_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .kind            (kind),
    .out_byte        (out_byte),
    .error_code      (error_code),
    .last_of_item    (last_of_item),
    .token_faults    (token_faults),
    .tokens_owed     (tokens_owed)
  );

  // Receiver: hold off for a long stretch when asked, otherwise stall at
  // random with the odds of the current phase
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= LongHold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Watchdog: give up once nothing has moved on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one byte, after a random gap, and hold it until it is taken
  task automatic send_byte(input logic [7:0] d, input logic last_byte);
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    record_end <= last_byte;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Pause the sender until every due result has come, then let the block
  // settle, since a byte may be in flight that gives no result at all
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tokens_owed != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_delimiter(input logic [7:0] v);
    cfg_valid       <= 1'b1;
    field_delimiter <= v;
    delim_now       =  v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // A byte that cannot end or break an unquoted field
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b == BYTE_QUOTE || b == BYTE_CR || b == BYTE_LF || b == delim_now);
    return b;
  endfunction

  // Bias noise towards the bytes the parser treats specially
  function automatic logic [7:0] noise_byte();
    case ($urandom_range(4))
      0:       return BYTE_QUOTE;
      1:       return BYTE_CR;
      2:       return BYTE_LF;
      3:       return delim_now;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Append one byte to the record under construction
  task automatic add_byte(input logic [7:0] b);
    record_bytes = {record_bytes, b};
  endtask

  // Build one record: mostly well-formed fields with random content, some
  // with a damaged byte, and some pure noise
  task automatic build_record();
    int style;
    int fields;
    int len;
    int pos;
    record_bytes.delete();
    style = $urandom_range(9);
    if (style < 2) begin
      len = $urandom_range(6, 1);
      repeat (len) add_byte(noise_byte());
    end else begin
      if ($urandom_range(5) == 0) add_byte($urandom_range(1) ? BYTE_CR : BYTE_LF);
      fields = $urandom_range(4, 1);
      for (int f = 0; f < fields; f++) begin
        if (f != 0) add_byte(delim_now);
        len = $urandom_range(4);
        if ($urandom_range(2) == 0) begin
          // quoted field: may carry delimiters, line breaks and doubled quotes
          add_byte(BYTE_QUOTE);
          repeat (len) begin
            case ($urandom_range(5))
              0: begin
                add_byte(BYTE_QUOTE);
                add_byte(BYTE_QUOTE);
              end
              1:       add_byte(delim_now);
              2:       add_byte($urandom_range(1) ? BYTE_CR : BYTE_LF);
              default: add_byte(plain_byte());
            endcase
          end
          add_byte(BYTE_QUOTE);
        end else begin
          repeat (len) add_byte(plain_byte());
        end
      end
      if ($urandom_range(4) == 0) add_byte(delim_now);
      if (style == 2 && record_bytes.size() != 0) begin
        pos = $urandom_range(record_bytes.size() - 1);
        record_bytes[pos] = noise_byte();
      end
    end
    if (record_bytes.size() == 0) add_byte(plain_byte());
  endtask

  // Send whole records until at least the given number of bytes has gone
  task automatic send_records(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_record();
      for (int i = 0; i < record_bytes.size(); i++)
        send_byte(record_bytes[i], i == record_bytes.size() - 1);
      sent += record_bytes.size();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    delim_now = DELIM_RESET;

    // Sender idles rarely, receiver often
    send_gap_pct = 7;
    recv_gap_pct <= 47;

    // Directed records under the reset delimiter (comma)
    send_text("a,b");                    // plain fields, content on the last byte
    send_text("\"x,\"\"y\"");            // quoted delimiter and doubled quote
    send_text("\015\n,");                // skip line breaks, trailing delimiter
    send_text("a\"");                    // quote inside an unquoted field
    send_text("\"a\"b");                 // lone quote inside quotes
    send_text("\"");                     // record ends on the opening quote
    send_text("\"\"\"");                 // record ends on a doubled pair
    send_byte(8'h00, 1'b0);              // extremes of the byte range
    send_byte(8'hFF, 1'b1);

    send_records(30);

    // Back the block up: hold the receiver while bytes keep coming
    hold_toggle <= ~hold_toggle;
    send_records(15);
    drain();

    // Sender idles often, receiver rarely
    write_delimiter(8'h00);
    send_gap_pct = 47;
    recv_gap_pct <= 7;
    send_records(40);
    drain();

    write_delimiter(8'hFF);
    send_records(25);
    drain();

    // No idling on either side from here on
    send_gap_pct = 0;
    recv_gap_pct <= 0;
    write_delimiter(BYTE_QUOTE);
    send_records(15);
    drain();

    write_delimiter(BYTE_LF);
    send_records(15);
    drain();

    write_delimiter(8'($urandom_range(255)));
    send_records(10);
    drain();

    if (token_faults == 0 && tokens_owed == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
